### rtl/rwhp_pkg.sv
// Package for the RIFF/WAVE header parser: phase and sequencer types,
// chunk id constants and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rwhp_pkg;
    typedef enum logic [2:0] {
        PH_HEADER, PH_CHUNK_HEAD, PH_FMT_BODY, PH_SKIP, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_MUL1, SQ_MUL2, SQ_MUL3, SQ_NUM, SQ_DIV, SQ_OUT
    } t_seq;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_NOT_RIFF  = 4'd2;
    localparam logic [3:0] ST_FMT_SMALL = 4'd3;
    localparam logic [3:0] ST_FMT_CUT   = 4'd4;
    localparam logic [3:0] ST_BITS_CUT  = 4'd5;
    localparam logic [3:0] ST_NOT_PCM   = 4'd6;
    localparam logic [3:0] ST_MISSING   = 4'd7;
    localparam logic [3:0] ST_BAD_FIELD = 4'd8;
    localparam logic [3:0] ST_ZERO_BPS  = 4'd9;

    localparam int QUOT_W = 42;
    localparam int DEN_W  = 61;
endpackage
`default_nettype wire

### rtl/riff_wave_header_parser.sv
// Top level of the RIFF/WAVE header parser: byte-wise chunk walker plus a
// sequencer with one shared multiplier and a bit-serial divider. Uses rwhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each beat that carries a byte and no end mark is taken at once while the
// sequencer is idle, so the block follows a byte stream at full rate. The
// end-of-file beat starts the sequencer: three passes through the shared
// 32x16 multiplier build the byte rate (rate times channels, then the upper
// and lower parts of that product times whole bytes per sample), one pass
// forms the numerator, and a restoring divider then retires one quotient bit
// a cycle until all 42 bits are done. The result beat is offered once the
// divider ends when the status is ok, or in the next cycle when it is an
// error, and the next file is taken once that beat is taken.
module riff_wave_header_parser
    import rwhp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_byte_valid,
    input  wire         i_end_of_file,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [3:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate_hz,
    output logic [15:0] o_sample_bits,
    output logic [41:0] o_duration_ms
);
    t_phase       r_phase, n_phase;
    t_seq         r_seq, n_seq;
    logic [3:0]   r_off, n_off;
    logic [31:0]  r_tag, n_tag;
    logic [31:0]  r_len, n_len;
    logic [15:0]  r_fmt, n_fmt;
    logic [15:0]  r_ch, n_ch;
    logic [31:0]  r_rate, n_rate;
    logic [15:0]  r_bits, n_bits;
    logic [31:0]  r_dlen, n_dlen;
    logic         r_seen_fmt, n_seen_fmt;
    logic         r_seen_data, n_seen_data;
    logic [3:0]   r_err, n_err;
    logic         r_hbad, n_hbad;
    logic [32:0]  r_skip, n_skip;
    logic [3:0]   r_status, n_status;
    logic [DEN_W-1:0] r_den, n_den;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [DEN_W:0] r_rem, n_rem;
    logic [5:0]   r_cnt, n_cnt;
    logic [47:0]  r_prod, n_prod;

    logic         take, accept_end;
    logic [31:0]  mul_a;
    logic [15:0]  mul_b;
    logic [47:0]  mul_p;
    logic [DEN_W:0] rem_sh;
    logic [DEN_W+1:0] rem_sub;
    logic [32:0]  skip_cnt;
    logic [31:0]  tag_sh;
    logic [3:0]   st;

    assign mul_p = 48'(mul_a) * 48'(mul_b);
    assign o_stall = (r_seq != SQ_IDLE);
    assign take = i_valid && !o_stall;
    assign accept_end = take && i_end_of_file;
    assign o_valid = (r_seq == SQ_OUT);
    assign o_status = r_status;
    assign o_channel_count = r_ch;
    assign o_sample_rate_hz = r_rate;
    assign o_sample_bits = r_bits;
    assign o_duration_ms = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_seq <= SQ_IDLE;
            r_off <= '0;
            r_tag <= '0;
            r_len <= '0;
            r_fmt <= '0;
            r_ch <= '0;
            r_rate <= '0;
            r_bits <= '0;
            r_dlen <= '0;
            r_seen_fmt <= 1'b0;
            r_seen_data <= 1'b0;
            r_err <= ST_OK;
            r_hbad <= 1'b0;
            r_skip <= '0;
        end else begin
            r_phase <= n_phase;
            r_seq <= n_seq;
            r_off <= n_off;
            r_tag <= n_tag;
            r_len <= n_len;
            r_fmt <= n_fmt;
            r_ch <= n_ch;
            r_rate <= n_rate;
            r_bits <= n_bits;
            r_dlen <= n_dlen;
            r_seen_fmt <= n_seen_fmt;
            r_seen_data <= n_seen_data;
            r_err <= n_err;
            r_hbad <= n_hbad;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_den <= n_den;
        r_quot <= n_quot;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_prod <= n_prod;
    end

    always_comb begin
        n_phase = r_phase;
        n_seq = r_seq;
        n_off = r_off;
        n_tag = r_tag;
        n_len = r_len;
        n_fmt = r_fmt;
        n_ch = r_ch;
        n_rate = r_rate;
        n_bits = r_bits;
        n_dlen = r_dlen;
        n_seen_fmt = r_seen_fmt;
        n_seen_data = r_seen_data;
        n_err = r_err;
        n_hbad = r_hbad;
        n_skip = r_skip;
        n_status = r_status;
        n_den = r_den;
        n_quot = r_quot;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_prod = r_prod;
        mul_a = r_rate;
        mul_b = r_ch;
        tag_sh = {r_tag[23:0], i_data_byte};
        skip_cnt = '0;
        st = ST_OK;
        rem_sh = '0;
        rem_sub = '0;

        if (take && i_byte_valid) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_tag = tag_sh;
                    n_off = r_off + 4'd1;
                    if (r_off == 4'd3 && tag_sh != TAG_RIFF) begin
                        n_hbad = 1'b1;
                    end
                    if (r_off == 4'd11) begin
                        n_off = '0;
                        if (r_hbad || tag_sh != TAG_WAVE) begin
                            n_err = ST_NOT_RIFF;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_CHUNK_HEAD;
                        end
                    end
                end
                PH_CHUNK_HEAD: begin
                    n_off = r_off + 4'd1;
                    if (r_off < 4'd4) begin
                        n_tag = tag_sh;
                    end else begin
                        n_len = {i_data_byte, r_len[31:8]};
                    end
                    if (r_off == 4'd7) begin
                        n_off = '0;
                        if (r_tag == TAG_FMT) begin
                            if (n_len < 32'd16) begin
                                n_err = ST_FMT_SMALL;
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_FMT_BODY;
                            end
                        end else begin
                            if (r_tag == TAG_DATA) begin
                                n_dlen = n_len;
                                n_seen_data = 1'b1;
                            end
                            skip_cnt = {1'b0, n_len} + 33'(n_len[0]);
                            n_skip = skip_cnt;
                            n_phase = (skip_cnt == '0) ? PH_CHUNK_HEAD : PH_SKIP;
                        end
                    end
                end
                PH_FMT_BODY: begin
                    n_off = r_off + 4'd1;
                    if (r_off < 4'd2) begin
                        if (r_off == 4'd0) begin
                            n_fmt = {8'd0, i_data_byte};
                        end else begin
                            n_fmt[15:8] = i_data_byte;
                        end
                    end else if (r_off < 4'd4) begin
                        if (r_off == 4'd2) begin
                            n_ch = {8'd0, i_data_byte};
                        end else begin
                            n_ch[15:8] = i_data_byte;
                        end
                    end else if (r_off < 4'd8) begin
                        if (r_off == 4'd4) begin
                            n_rate = {24'd0, i_data_byte};
                        end else begin
                            n_rate[{r_off[1:0], 3'd0} +: 8] = i_data_byte;
                        end
                    end else if (r_off >= 4'd14) begin
                        if (r_off == 4'd14) begin
                            n_bits = {8'd0, i_data_byte};
                        end else begin
                            n_bits[15:8] = i_data_byte;
                        end
                    end
                    if (r_off == 4'd15) begin
                        n_off = '0;
                        if (r_fmt != 16'd1) begin
                            n_err = ST_NOT_PCM;
                            n_phase = PH_DONE;
                        end else begin
                            n_seen_fmt = 1'b1;
                            skip_cnt = {1'b0, r_len - 32'd16} + 33'(r_len[0]);
                            n_skip = skip_cnt;
                            n_phase = (skip_cnt == '0) ? PH_CHUNK_HEAD : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 33'd1;
                    if (r_skip == 33'd1) begin
                        n_phase = PH_CHUNK_HEAD;
                        n_off = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (r_seq)
            SQ_IDLE: begin
                if (accept_end) begin
                    if (n_err != ST_OK) begin
                        st = n_err;
                    end else if (n_phase == PH_HEADER) begin
                        st = ST_SHORT;
                    end else if (n_phase == PH_FMT_BODY) begin
                        st = (n_off < 4'd8) ? ST_FMT_CUT : ST_BITS_CUT;
                    end else if (!n_seen_fmt || !n_seen_data) begin
                        st = ST_MISSING;
                    end else if (n_rate == '0 || n_rate[31] || n_ch == '0
                                 || n_bits == '0) begin
                        st = ST_BAD_FIELD;
                    end else if (n_bits < 16'd8) begin
                        st = ST_ZERO_BPS;
                    end
                    n_status = st;
                    n_quot = '0;
                    n_seq = (st == ST_OK) ? SQ_MUL1 : SQ_OUT;
                end
            end
            SQ_MUL1: begin
                n_prod = mul_p;
                n_seq = SQ_MUL2;
            end
            SQ_MUL2: begin
                mul_a = r_prod[46:15];
                mul_b = {3'd0, r_bits[15:3]};
                n_den = DEN_W'({mul_p, 15'd0});
                n_seq = SQ_MUL3;
            end
            SQ_MUL3: begin
                mul_a = {17'd0, r_prod[14:0]};
                mul_b = {3'd0, r_bits[15:3]};
                n_den = r_den + DEN_W'(mul_p);
                n_seq = SQ_NUM;
            end
            SQ_NUM: begin
                mul_a = r_dlen;
                mul_b = 16'd1000;
                n_quot = QUOT_W'(mul_p);
                n_rem = '0;
                n_cnt = 6'(QUOT_W);
                n_seq = SQ_DIV;
            end
            SQ_DIV: begin
                rem_sh = {r_rem[DEN_W-1:0], r_quot[QUOT_W-1]};
                rem_sub = {1'b0, rem_sh} - {2'b0, r_den};
                if (!rem_sub[DEN_W+1]) begin
                    n_rem = rem_sub[DEN_W:0];
                    n_quot = {r_quot[QUOT_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quot = {r_quot[QUOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_seq = SQ_OUT;
                end
            end
            SQ_OUT: begin
                if (!i_stall) begin
                    n_seq = SQ_IDLE;
                    n_phase = PH_HEADER;
                    n_off = '0;
                    n_tag = '0;
                    n_len = '0;
                    n_fmt = '0;
                    n_ch = '0;
                    n_rate = '0;
                    n_bits = '0;
                    n_dlen = '0;
                    n_seen_fmt = 1'b0;
                    n_seen_data = 1'b0;
                    n_err = ST_OK;
                    n_hbad = 1'b0;
                    n_skip = '0;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for riff_wave_header_parser: directed beats from a table, then random
// WAV files, scored by a behavioral model or a pinned status. Uses rwhp_pkg.
`timescale 1ns / 1ps
module tb;
    import rwhp_pkg::*;

    typedef struct {
        logic [7:0] data;
        bit         has_byte;
        bit         eof;
        bit         pinned;
        logic [3:0] pin_status;
    } t_beat;

    typedef struct {
        logic [3:0]  status;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [41:0] duration;
    } t_summary;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 0;
    logic        i_byte_valid = 0;
    logic        i_end_of_file = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [3:0]  o_status;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate_hz;
    logic [15:0] o_sample_bits;
    logic [41:0] o_duration_ms;

    riff_wave_header_parser dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    t_beat    beats[$];
    t_summary summaries_due[$];
    int       errors = 0;
    int       cycles = 0;
    int       stall_left = 0;
    bit       calm = 0;

    t_phase      phase;
    int unsigned offset;
    logic [31:0] tag, chunk_len, rate_v, data_len;
    logic [15:0] format_v, channels_v, bits_v;
    logic        fmt_seen, data_seen, header_bad;
    logic [3:0]  held_err;
    logic [32:0] skip_left;

    task automatic clear_parser();
        phase = PH_HEADER;
        offset = 0;
        tag = 0;
        chunk_len = 0;
        rate_v = 0;
        data_len = 0;
        format_v = 0;
        channels_v = 0;
        bits_v = 0;
        fmt_seen = 0;
        data_seen = 0;
        header_bad = 0;
        held_err = ST_OK;
        skip_left = 0;
    endtask

    task automatic start_skip(input logic [32:0] count);
        skip_left = count;
        offset = 0;
        phase = (count == 0) ? PH_CHUNK_HEAD : PH_SKIP;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int unsigned off;
        off = offset;
        case (phase)
            PH_HEADER: begin
                tag = {tag[23:0], b};
                if (off == 3 && tag != TAG_RIFF) header_bad = 1;
                if (off == 11) begin
                    if (tag != TAG_WAVE) header_bad = 1;
                    if (header_bad) begin
                        held_err = ST_NOT_RIFF;
                        phase = PH_DONE;
                    end else begin
                        phase = PH_CHUNK_HEAD;
                        offset = 0;
                    end
                end else begin
                    offset = off + 1;
                end
            end
            PH_CHUNK_HEAD: begin
                if (off < 4) begin
                    tag = {tag[23:0], b};
                end else begin
                    if (off == 4) chunk_len = 0;
                    chunk_len[8*(off-4) +: 8] = b;
                end
                if (off < 7) begin
                    offset = off + 1;
                end else if (tag == TAG_FMT) begin
                    if (chunk_len < 16) begin
                        held_err = ST_FMT_SMALL;
                        phase = PH_DONE;
                    end else begin
                        phase = PH_FMT_BODY;
                        offset = 0;
                    end
                end else begin
                    if (tag == TAG_DATA) begin
                        data_len = chunk_len;
                        data_seen = 1;
                    end
                    start_skip({1'b0, chunk_len} + chunk_len[0]);
                end
            end
            PH_FMT_BODY: begin
                if (off < 2) begin
                    if (off == 0) format_v = 0;
                    format_v[8*off +: 8] = b;
                end else if (off < 4) begin
                    if (off == 2) channels_v = 0;
                    channels_v[8*(off-2) +: 8] = b;
                end else if (off < 8) begin
                    if (off == 4) rate_v = 0;
                    rate_v[8*(off-4) +: 8] = b;
                end else if (off >= 14) begin
                    if (off == 14) bits_v = 0;
                    bits_v[8*(off-14) +: 8] = b;
                end
                if (off < 15) begin
                    offset = off + 1;
                end else if (format_v != 1) begin
                    held_err = ST_NOT_PCM;
                    phase = PH_DONE;
                end else begin
                    fmt_seen = 1;
                    start_skip({1'b0, chunk_len - 32'd16} + chunk_len[0]);
                end
            end
            PH_SKIP: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) begin
                    phase = PH_CHUNK_HEAD;
                    offset = 0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_summary file_summary();
        t_summary s;
        logic [63:0] byte_rate;
        s.channels = channels_v;
        s.rate = rate_v;
        s.bits = bits_v;
        s.duration = 0;
        byte_rate = 64'(rate_v) * 64'(channels_v) * 64'(bits_v / 16'd8);
        if (held_err != ST_OK) s.status = held_err;
        else if (phase == PH_HEADER) s.status = ST_SHORT;
        else if (phase == PH_FMT_BODY) s.status = (offset < 8) ? ST_FMT_CUT : ST_BITS_CUT;
        else if (!fmt_seen || !data_seen) s.status = ST_MISSING;
        else if (rate_v == 0 || rate_v[31] || channels_v == 0 || bits_v == 0)
            s.status = ST_BAD_FIELD;
        else if (byte_rate == 0) s.status = ST_ZERO_BPS;
        else begin
            s.status = ST_OK;
            s.duration = 42'((64'(data_len) * 64'd1000) / byte_rate);
        end
        return s;
    endfunction

    task automatic apply_beat(input t_beat bt);
        t_summary s;
        if (bt.has_byte) parse_byte(bt.data);
        if (bt.eof) begin
            s = file_summary();
            if (bt.pinned) s = '{bt.pin_status, 16'd0, 32'd0, 16'd0, 42'd0};
            summaries_due.push_back(s);
            clear_parser();
        end
    endtask

    function automatic t_beat mk(input logic [7:0] d, input bit hb, input bit e);
        t_beat bt;
        bt = '{d, hb, e, 1'b0, ST_OK};
        return bt;
    endfunction

    task automatic push_word(inout logic [7:0] q[$], input logic [31:0] w, input bit le);
        for (int i = 0; i < 4; i++) q.push_back(le ? w[8*i +: 8] : w[8*(3-i) +: 8]);
    endtask

    task automatic make_file();
        logic [7:0]  q[$];
        logic [31:0] sz, rate;
        logic [15:0] ch, bits;
        int          n, cut;
        push_word(q, ($urandom_range(0, 19) == 0) ? $urandom : TAG_RIFF, 0);
        push_word(q, $urandom, 1);
        push_word(q, ($urandom_range(0, 19) == 0) ? $urandom : TAG_WAVE, 0);
        n = $urandom_range(0, 4);
        for (int c = 0; c < n; c++) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(16, 21);
                    push_word(q, TAG_FMT, 0);
                    push_word(q, sz, 1);
                    q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd1);
                    q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0);
                    case ($urandom_range(0, 3))
                        0: ch = 16'd0;
                        1: ch = 16'd1;
                        2: ch = 16'd2;
                        default: ch = 16'($urandom);
                    endcase
                    case ($urandom_range(0, 6))
                        0: rate = 0;
                        1: rate = 32'h80000000;
                        2: rate = 32'hffffffff;
                        3: rate = 32'h7fffffff;
                        4: rate = 44100;
                        5: rate = 48000;
                        default: rate = $urandom;
                    endcase
                    case ($urandom_range(0, 5))
                        0: bits = 16'd0;
                        1: bits = 16'($urandom_range(1, 7));
                        2: bits = 16'd8;
                        3: bits = 16'd16;
                        4: bits = 16'hffff;
                        default: bits = 16'($urandom);
                    endcase
                    q.push_back(ch[7:0]);
                    q.push_back(ch[15:8]);
                    push_word(q, rate, 1);
                    push_word(q, $urandom, 1);
                    push_word(q, $urandom, 1);
                    q.push_back(bits[7:0]);
                    q.push_back(bits[15:8]);
                    if (sz >= 16) repeat (sz - 16 + sz[0]) q.push_back(8'($urandom));
                end
                2: begin
                    push_word(q, TAG_DATA, 0);
                    if ($urandom_range(0, 2) == 0) begin
                        push_word(q, $urandom, 1);
                        c = n;
                    end else begin
                        sz = $urandom_range(0, 9);
                        push_word(q, sz, 1);
                        repeat (sz + sz[0]) q.push_back(8'($urandom));
                    end
                end
                default: begin
                    push_word(q, $urandom, 0);
                    sz = $urandom_range(0, 7);
                    push_word(q, sz, 1);
                    repeat (sz + sz[0]) q.push_back(8'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(0, q.size());
            while (q.size() > cut) void'(q.pop_back());
        end
        foreach (q[i]) begin
            if ($urandom_range(0, 30) == 0) beats.push_back(mk(8'($urandom), 0, 0));
            beats.push_back(mk(q[i], 1, (i == q.size() - 1) && $urandom_range(0, 1)));
        end
        if (q.size() == 0 || !beats[$].eof) beats.push_back(mk(8'($urandom), 0, 1));
    endtask

    task automatic send_beat(input t_beat bt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 0;
        end
        @(negedge i_clk);
        i_valid = 1;
        i_data_byte = bt.data;
        i_byte_valid = bt.has_byte;
        i_end_of_file = bt.eof;
        do @(posedge i_clk); while (o_stall);
        apply_beat(bt);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 0;
        end
    end

    task automatic compare(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_summary s;
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (summaries_due.size() == 0) begin
                $error("unexpected result beat, status %0d", o_status);
                errors++;
            end else begin
                s = summaries_due.pop_front();
                compare("status", s.status, o_status);
                compare("channel_count", s.channels, o_channel_count);
                compare("sample_rate_hz", s.rate, o_sample_rate_hz);
                compare("sample_bits", s.bits, o_sample_bits);
                compare("duration_ms", s.duration, o_duration_ms);
            end
            stall_left <= calm ? 0 : $urandom_range(0, 5);
        end
    end

    t_beat directed[$];
    int    sent;

    initial begin
        t_beat bt;
        clear_parser();
        bt = mk(8'h00, 0, 1);
        bt.pinned = 1;
        bt.pin_status = ST_SHORT;
        directed.push_back(bt);
        directed.push_back(mk(8'hff, 0, 0));
        bt = mk(8'hff, 1, 1);
        bt.pinned = 1;
        bt.pin_status = ST_SHORT;
        directed.push_back(bt);
        directed.push_back(mk("R", 1, 0));
        directed.push_back(mk("I", 1, 0));
        directed.push_back(mk("F", 1, 0));
        directed.push_back(mk("F", 1, 0));
        directed.push_back(mk(8'hff, 1, 0));
        directed.push_back(mk(8'h00, 1, 0));
        directed.push_back(mk(8'h00, 1, 0));
        directed.push_back(mk(8'h80, 1, 0));
        directed.push_back(mk("W", 1, 0));
        directed.push_back(mk("A", 1, 0));
        directed.push_back(mk("V", 1, 0));
        bt = mk("X", 1, 1);
        bt.pinned = 1;
        bt.pin_status = ST_NOT_RIFF;
        directed.push_back(bt);
        directed.push_back(mk("R", 1, 0));
        directed.push_back(mk("X", 1, 1));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        foreach (directed[i]) send_beat(directed[i]);
        sent = 0;
        while (sent < 950) begin
            make_file();
            if ($urandom_range(0, 7) == 0) calm = !calm;
            while (beats.size() > 0) begin
                send_beat(beats.pop_front());
                sent++;
            end
        end
        @(negedge i_clk);
        i_valid = 0;
        calm = 0;
        while (summaries_due.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### riff_wave_header_parser.f
rtl/rwhp_pkg.sv
rtl/riff_wave_header_parser.sv
dv/tb.sv
